/* design/lz_history_window_copy_macros.svh */
// assertion macros for the lz history window copy block
// used by the checker file only, no other dependencies
`ifndef LZ_HISTORY_WINDOW_COPY_MACROS_SVH
`define LZ_HISTORY_WINDOW_COPY_MACROS_SVH

// clocked assertion with active-low reset disable
`define LZW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// value holds in the cycle after cond
`define LZW_ASSERT_HOLD(name, clk, rst_n, cond, sig, msg) \
  `LZW_ASSERT(name, clk, rst_n, cond |=> $stable(sig), msg)

`endif

/* design/lzw_pkg.sv */
// shared types and constants of the lz history window copy block
// no dependencies; used by the interfaces, the top level and the testbench
package lzw_pkg;

  localparam int HIST_AW      = 16;
  localparam int WINDOW_DEPTH = 1 << HIST_AW;
  localparam int WIN_W        = HIST_AW + 1;
  localparam int MAX_COPY     = 64;
  localparam int LEN_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int DIST_W       = 16;
  localparam int ACT_W        = 2;

  // apb register map, one 32-bit register every 4 bytes
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;

  typedef enum logic [ACT_W-1:0] {
    ACT_LITERAL = 2'd0,
    ACT_MATCH   = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_e;

  // one byte operation between issue and memory output
  typedef struct packed {
    logic                we;
    logic                from_mem;
    logic [HIST_AW-1:0]  wa;
    logic [BYTE_W-1:0]   cbyte;
    logic                is_peek;
    logic                bad;
    logic                last;
  } stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_peek;
    logic              bad_distance;
    logic              last;
  } result_t;

endpackage

/* design/lzw_if.sv */
// request and result channel interfaces with valid/ready handshake
// depends on lzw_pkg for field widths
interface lzw_req_if;
  import lzw_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [BYTE_W-1:0]   data_byte;
  logic [DIST_W-1:0]   distance;
  logic [LEN_W-1:0]    match_length;
  logic                keep_history;

  modport source (
    output valid, action, data_byte, distance, match_length, keep_history,
    input  ready
  );
  modport sink (
    input  valid, action, data_byte, distance, match_length, keep_history,
    output ready
  );
endinterface

interface lzw_res_if;
  import lzw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_peek;
  logic              bad_distance;
  logic              last;

  modport source (
    output valid, out_byte, is_peek, bad_distance, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_peek, bad_distance, last,
    output ready
  );
endinterface

/* design/lz_history_window_copy.sv */
// lz history window: a literal and a peek give one result each, a restart none, a match
// min(match_length, 64) results, none for a zero length and one for a bad distance; one history
// byte read and written per cycle of a match through the history ram unless the output stalls;
// a result passes the memory stage and then the output register after its byte is issued.
// reset: window 65536, write position 0, history reads as zero until written
// (a fill mark stands in for clearing the ram, so no clearing pass is needed)
module lz_history_window_copy (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lzw_pkg::PADDR_W-1:0]    paddr,
  input  logic [lzw_pkg::PDATA_W-1:0]    pwdata,
  output logic [lzw_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  lzw_req_if.sink                        req_i,
  lzw_res_if.source                      res_o
);
  import lzw_pkg::*;

  localparam logic [WIN_W-1:0] WinMax = WIN_W'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_COPY);

  // position + 1 with wrap at the window
  function automatic logic [HIST_AW-1:0] wrap_inc(input logic [HIST_AW-1:0] pos,
                                                  input logic [WIN_W-1:0] ws);
    logic [WIN_W-1:0] inc;
    inc = {1'b0, pos} + WIN_W'(1);
    return (inc >= ws) ? '0 : inc[HIST_AW-1:0];
  endfunction

  logic [WIN_W-1:0]   win_raw_q, ws_q;
  logic [WIN_W-1:0]   win_wdata, win_eff;
  logic               cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  state_e             state_q, state_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [HIST_AW-1:0] src_q, src_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic [WIN_W-1:0]   fill_q;

  logic               req_fire;
  action_e            act;
  logic [WIN_W-1:0]   wp_x, dist_x;
  logic               bad_dist;
  logic [WIN_W-1:0]   src_acc;
  logic [LEN_W-1:0]   len_sat;

  logic               slot_ok;
  logic               issue;
  stage_t             iss;
  logic [HIST_AW-1:0] ra;

  logic               b_valid_q;
  stage_t             b_q;
  logic               byp_hit_q, zero_q;
  logic [BYTE_W-1:0]  byp_data_q;
  logic [BYTE_W-1:0]  rd_data, b_byte;
  logic               b_fire;

  logic               out_valid_q;
  result_t            out_q;

  // config register port
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_we    = psel & penable & pwrite & (reg_idx == REG_WINDOW_SIZE);
  assign win_wdata = pwdata[WIN_W-1:0];
  assign win_eff   = (win_wdata == '0) ? WIN_W'(1) :
                     (win_wdata > WinMax) ? WinMax : win_wdata;
  assign pready    = 1'b1;
  assign prdata    = (reg_idx == REG_WINDOW_SIZE) ? PDATA_W'(win_raw_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_raw_q <= WinMax;
      ws_q      <= WinMax;
    end else if (cfg_we) begin
      win_raw_q <= win_wdata;
      ws_q      <= win_eff;
    end
  end

  // request decode and source position
  assign act      = action_e'(req_i.action);
  assign req_fire = req_i.valid & req_i.ready;
  assign wp_x     = {1'b0, wp_q};
  assign dist_x   = {1'b0, req_i.distance};
  assign bad_dist = dist_x >= ws_q;
  assign src_acc  = (wp_x > dist_x) ? (wp_x - dist_x - WIN_W'(1))
                                    : (wp_x + ws_q - dist_x - WIN_W'(1));
  assign len_sat  = (req_i.match_length > LenMax) ? LenMax : req_i.match_length;

  // byte slot frees when the memory stage moves on
  assign b_fire  = b_valid_q & (~out_valid_q | res_o.ready);
  assign slot_ok = ~b_valid_q | b_fire;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && act == ACT_MATCH && !bad_dist && len_sat > LEN_W'(1)) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if (slot_ok && rem_q == LEN_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // issue control and position updates
  always_comb begin
    req_i.ready = 1'b0;
    issue       = 1'b0;
    iss         = '0;
    ra          = '0;
    wp_d        = wp_q;
    src_d       = src_q;
    rem_d       = rem_q;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = slot_ok;
        if (req_fire) begin
          case (act)
            ACT_LITERAL: begin
              issue     = 1'b1;
              iss.we    = 1'b1;
              iss.wa    = wp_q;
              iss.cbyte = req_i.data_byte;
              iss.last  = 1'b1;
              wp_d      = wrap_inc(wp_q, ws_q);
            end
            ACT_RESTART: begin
              if (!req_i.keep_history) begin
                wp_d = '0;
              end
            end
            ACT_PEEK: begin
              issue        = 1'b1;
              iss.from_mem = ~bad_dist;
              iss.is_peek  = 1'b1;
              iss.bad      = bad_dist;
              iss.last     = 1'b1;
              ra           = src_acc[HIST_AW-1:0];
            end
            ACT_MATCH: begin
              if (bad_dist) begin
                issue    = 1'b1;
                iss.bad  = 1'b1;
                iss.last = 1'b1;
              end else if (len_sat != '0) begin
                issue        = 1'b1;
                iss.we       = 1'b1;
                iss.from_mem = 1'b1;
                iss.wa       = wp_q;
                iss.last     = (len_sat == LEN_W'(1));
                ra           = src_acc[HIST_AW-1:0];
                wp_d         = wrap_inc(wp_q, ws_q);
                src_d        = wrap_inc(src_acc[HIST_AW-1:0], ws_q);
                rem_d        = len_sat - LEN_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_COPY: begin
        if (slot_ok) begin
          issue        = 1'b1;
          iss.we       = 1'b1;
          iss.from_mem = 1'b1;
          iss.wa       = wp_q;
          iss.last     = (rem_q == LEN_W'(1));
          ra           = src_q;
          wp_d         = wrap_inc(wp_q, ws_q);
          src_d        = wrap_inc(src_q, ws_q);
          rem_d        = rem_q - LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= cfg_we ? '0 : wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    rem_q <= rem_d;
  end

  // history ram
  lzw_hist_ram #(
    .ADDR_W (HIST_AW),
    .DATA_W (BYTE_W)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire & b_q.we),
    .waddr_i (b_q.wa),
    .wdata_i (b_byte),
    .re_i    (issue & iss.from_mem),
    .raddr_i (ra),
    .rdata_o (rd_data)
  );

  // memory stage: bypass of the write in the same cycle, unwritten entries read zero
  assign b_byte = !b_q.from_mem ? b_q.cbyte :
                  byp_hit_q     ? byp_data_q :
                  zero_q        ? '0 : rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (issue) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_q        <= iss;
      byp_hit_q  <= b_fire & b_q.we & (b_q.wa == ra);
      byp_data_q <= b_byte;
      zero_q     <= {1'b0, ra} >= fill_q;
    end
  end

  // fill mark: entries below it have been written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (b_fire && b_q.we && {1'b0, b_q.wa} == fill_q) begin
      fill_q <= fill_q + WIN_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_q.out_byte     <= b_byte;
      out_q.is_peek      <= b_q.is_peek;
      out_q.bad_distance <= b_q.bad;
      out_q.last         <= b_q.last;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_byte     = out_q.out_byte;
  assign res_o.is_peek      = out_q.is_peek;
  assign res_o.bad_distance = out_q.bad_distance;
  assign res_o.last         = out_q.last;
endmodule

/* design/lzw_hist_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lzw_hist_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  localparam int Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* design/lzw_check.sv */
// port-level checker for the lz history window copy block, bound to the top
// depends on lz_history_window_copy_macros.svh
`include "lz_history_window_copy_macros.svh"

module lzw_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_out_byte,
  input logic       res_is_peek,
  input logic       res_bad_distance,
  input logic       res_last
);
  // a stalled result holds
  `LZW_ASSERT(res_valid_hold, clk_i, rst_ni, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `LZW_ASSERT_HOLD(res_data_hold, clk_i, rst_ni, res_valid && !res_ready, {res_out_byte, res_is_peek, res_bad_distance, res_last}, "result changed while stalled")

  // an error result is a lone zero byte
  `LZW_ASSERT(bad_is_single, clk_i, rst_ni, res_valid && res_bad_distance |-> res_last && res_out_byte == 8'd0, "bad distance result malformed")

  // a peek answers with exactly one result
  `LZW_ASSERT(peek_is_single, clk_i, rst_ni, res_valid && res_is_peek |-> res_last, "peek result not final")
endmodule

bind lz_history_window_copy lzw_check u_lzw_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid        (res_o.valid),
  .res_ready        (res_o.ready),
  .res_out_byte     (res_o.out_byte),
  .res_is_peek      (res_o.is_peek),
  .res_bad_distance (res_o.bad_distance),
  .res_last         (res_o.last)
);

/* dv/lz_history_window_copy_tb.sv */
// testbench for the lz history window copy block: a directed table, then random phases
// depends on lzw_pkg, lzw_if and lz_history_window_copy; results are predicted by a window model
module lz_history_window_copy_tb;
  import lzw_pkg::*;

  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int IDLE_PCT        = 22;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int N_PHASES        = 10;
  localparam int N_DIR           = 27;

  typedef struct packed {
    action_e           action;
    logic [BYTE_W-1:0] data_byte;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  match_length;
    logic              keep_history;
  } lz_req_t;

  typedef struct packed {
    logic               is_cfg;
    logic [PDATA_W-1:0] cfg_value;
    lz_req_t            req;
    logic               typed;
    result_t            want;
  } dir_row_t;

  localparam lz_req_t NO_REQ = '0;
  localparam result_t NO_RES = '0;

  // directed stimulus; typed rows carry their one result, the rest take theirs from the model
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // history reads as zero after reset
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'd0, 7'd1, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'hFFFF, 7'd1, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    // literals echo their byte
    '{1'b0, 32'd0, '{ACT_LITERAL, 8'hFF, 16'd0, 7'd0, 1'b0}, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 32'd0, '{ACT_LITERAL, 8'h00, 16'd0, 7'd0, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 32'd0, '{ACT_LITERAL, 8'hA5, 16'd0, 7'd0, 1'b0}, 1'b1, '{8'hA5, 1'b0, 1'b0, 1'b1}},
    // overlapping run, full-size copy, saturated length, zero length
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'd0, 7'd5, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'd2, 7'd64, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h55, 16'd1, 7'd127, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'd3, 7'd0, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'd3, 7'd0, 1'b0}, 1'b0, NO_RES},
    // restarts, solid and rewinding
    '{1'b0, 32'd0, '{ACT_RESTART, 8'hFF, 16'hFFFF, 7'd127, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_LITERAL, 8'h5A, 16'd0, 7'd0, 1'b0}, 1'b1, '{8'h5A, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 32'd0, '{ACT_RESTART, 8'h00, 16'd0, 7'd0, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'd0, 7'd1, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'hFFFF, 7'd3, 1'b0}, 1'b0, NO_RES},
    // small window: distances at and beyond it are rejected
    '{1'b1, 32'd16, NO_REQ, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'd16, 7'd4, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'd16, 7'd1, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'hFFFF, 7'd1, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'd15, 7'd20, 1'b0}, 1'b0, NO_RES},
    // window of zero behaves as one byte
    '{1'b1, 32'd0, NO_REQ, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_LITERAL, 8'h3C, 16'd0, 7'd0, 1'b0}, 1'b1, '{8'h3C, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 32'd0, '{ACT_MATCH, 8'h00, 16'd0, 7'd3, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'd1, 7'd1, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    // oversized window clamps to the full store, contents kept
    '{1'b1, 32'h1FFFF, NO_REQ, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'hFFFF, 7'd1, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 32'd0, '{ACT_PEEK, 8'h00, 16'd65520, 7'd1, 1'b0}, 1'b0, NO_RES}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lzw_req_if req_if ();
  lzw_res_if res_if ();

  lz_history_window_copy u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .res_o   (res_if)
  );

  // window model state
  logic [BYTE_W-1:0] hist_mem [WINDOW_DEPTH];
  logic [WIN_W-1:0]  win_reg;
  int unsigned       wr_pos;
  result_t           out_due [$];

  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  logic        calm         = 1'b0;

  always #5 clk_i = ~clk_i;

  // window size in use: zero acts as one, oversize clamps to the store
  function automatic int unsigned eff_window();
    if (win_reg == '0) return 1;
    if (win_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return win_reg;
  endfunction

  // apply one request to the model and collect the bytes it emits
  function automatic void window_model_step(input lz_req_t r, output result_t res_q[$]);
    int unsigned ws;
    int unsigned back_off;
    int unsigned src;
    int unsigned len;
    logic [BYTE_W-1:0] b;
    res_q = {};
    ws = eff_window();
    back_off = r.distance;
    if (wr_pos >= ws) wr_pos = 0;
    case (r.action)
      ACT_LITERAL: begin
        hist_mem[wr_pos] = r.data_byte;
        wr_pos = (wr_pos + 1 >= ws) ? 0 : wr_pos + 1;
        res_q.push_back('{r.data_byte, 1'b0, 1'b0, 1'b1});
      end
      ACT_RESTART: begin
        if (!r.keep_history) wr_pos = 0;
      end
      default: begin
        if (back_off >= ws) begin
          res_q.push_back('{8'h00, r.action == ACT_PEEK, 1'b1, 1'b1});
        end else begin
          src = (wr_pos >= back_off + 1) ? wr_pos - back_off - 1
                                         : wr_pos + ws - back_off - 1;
          if (r.action == ACT_PEEK) begin
            res_q.push_back('{hist_mem[src], 1'b1, 1'b0, 1'b1});
          end else begin
            len = (r.match_length > MAX_COPY) ? MAX_COPY : r.match_length;
            // byte by byte, so an overlapping copy sees its own output
            for (int unsigned i = 0; i < len; i++) begin
              b = hist_mem[src];
              hist_mem[wr_pos] = b;
              src = (src + 1 >= ws) ? 0 : src + 1;
              wr_pos = (wr_pos + 1 >= ws) ? 0 : wr_pos + 1;
              res_q.push_back('{b, 1'b0, 1'b0, i + 1 == len});
            end
          end
        end
      end
    endcase
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic send_item(input lz_req_t r, input logic typed, input result_t want);
    result_t res_q [$];
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.data_byte    <= r.data_byte;
    req_if.distance     <= r.distance;
    req_if.match_length <= r.match_length;
    req_if.keep_history <= r.keep_history;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    window_model_step(r, res_q);
    if (typed) res_q = {want};
    foreach (res_q[k]) out_due.push_back(res_q[k]);
    @(negedge clk_i);
  endtask

  // hold off requests until every predicted byte has come out
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (out_due.size() != 0) @(negedge clk_i);
  endtask

  // apb write of window_size once idle, then read it back
  task automatic set_window(input logic [PDATA_W-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_SIZE, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    win_reg = value[WIN_W-1:0];
    wr_pos  = 0;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[WIN_W-1:0] !== win_reg) begin
      $error("window_size: expected %0h, got %0h", win_reg, prdata[WIN_W-1:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side stalls at random except in the calm phase
  always @(negedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare each result against the oldest predicted byte
  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (out_due.size() == 0) begin
        $error("unexpected result: out_byte %02h is_peek %0b bad_distance %0b last %0b",
               res_if.out_byte, res_if.is_peek, res_if.bad_distance, res_if.last);
        mismatches++;
      end else begin
        exp_r = out_due.pop_front();
        if (res_if.out_byte !== exp_r.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp_r.out_byte, res_if.out_byte);
          mismatches++;
        end
        if (res_if.is_peek !== exp_r.is_peek) begin
          $error("is_peek: expected %0b, got %0b", exp_r.is_peek, res_if.is_peek);
          mismatches++;
        end
        if (res_if.bad_distance !== exp_r.bad_distance) begin
          $error("bad_distance: expected %0b, got %0b", exp_r.bad_distance,
                 res_if.bad_distance);
          mismatches++;
        end
        if (res_if.last !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, res_if.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned        ws;
    int unsigned        pick;
    int unsigned        roll;
    logic [PDATA_W-1:0] phase_win [N_PHASES];
    lz_req_t            r;

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.action       = '0;
    req_if.data_byte    = '0;
    req_if.distance     = '0;
    req_if.match_length = '0;
    req_if.keep_history = 1'b0;
    res_if.ready        = 1'b0;
    foreach (hist_mem[k]) hist_mem[k] = '0;
    win_reg = WIN_W'(WINDOW_DEPTH);
    wr_pos  = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) set_window(DIRECTED[i].cfg_value);
      else send_item(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random phases over a spread of window sizes, extremes included
    phase_win = '{32'h10000, 32'd1, 32'd0, 32'd16, 32'd300, 32'h1FFFF, 32'd2, 32'd4096,
                  32'd65535, 32'd0};
    phase_win[N_PHASES-1] = $urandom_range(3, WINDOW_DEPTH);
    foreach (phase_win[p]) begin
      set_window(phase_win[p]);
      calm = (p == 3);
      ws = eff_window();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2 && (p == 1 || $urandom_range(0, 3) == 0)) wait_drained();
        pick = $urandom_range(0, 99);
        r.action = pick < 35 ? ACT_LITERAL :
                   pick < 70 ? ACT_MATCH :
                   pick < 85 ? ACT_PEEK : ACT_RESTART;
        r.data_byte    = BYTE_W'($urandom());
        r.keep_history = 1'($urandom());
        // mostly near and in-window distances, some out of range
        roll = $urandom_range(0, 99);
        if (roll < 10 && ws < WINDOW_DEPTH)
          r.distance = DIST_W'($urandom_range(ws, WINDOW_DEPTH - 1));
        else if (roll < 20)
          r.distance = DIST_W'($urandom());
        else if (roll < 65)
          r.distance = DIST_W'($urandom_range(0, (ws < 64 ? ws : 64) - 1));
        else
          r.distance = DIST_W'($urandom_range(0, ws - 1));
        // short copies mostly, with zero, full and oversized lengths
        roll = $urandom_range(0, 99);
        if (roll < 5)
          r.match_length = '0;
        else if (roll < 15)
          r.match_length = LEN_W'($urandom_range(MAX_COPY + 1, (1 << LEN_W) - 1));
        else if (roll < 25)
          r.match_length = LEN_W'(MAX_COPY);
        else
          r.match_length = LEN_W'($urandom_range(1, 16));
        send_item(r, 1'b0, NO_RES);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/lzw_pkg.sv
design/lzw_if.sv
design/lzw_hist_ram.sv
design/lz_history_window_copy.sv
design/lzw_check.sv
dv/lz_history_window_copy_tb.sv
